// File: hdl/tls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tls_pkg
// shared widths, constants and controller types of the temperature logger
// ----------------------------------------------------------------------------
package tls_pkg;

    localparam int TEMP_W     = 12;
    localparam int SUPPLY_W   = 8;
    localparam int INTERVAL_W = 8;
    localparam int FRAME_W    = 32;

    localparam int LOG_DEPTH  = 12;
    localparam int IDX_W      = $clog2(LOG_DEPTH);
    localparam int CNT_W      = $clog2(LOG_DEPTH + 1);
    localparam int SUM_W      = TEMP_W + CNT_W;
    localparam int Q_W        = TEMP_W;
    localparam int DIVC_W     = $clog2(Q_W + 1);

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd120;
    localparam logic [INTERVAL_W-1:0] COUNTER_RESET  = 8'hFF;
    localparam logic [3:0]            FRAME_TYPE     = 4'h2;
    localparam logic [3:0]            CHECKSUM_XOR   = 4'h5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_DIVIDE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic update;
        logic scan_step;
        logic div_load;
        logic div_step;
        logic result_load;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic scan_done;
        logic div_done;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// File: hdl/tls_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tls_if
// sample and result channels of the temperature logger
// ----------------------------------------------------------------------------
interface tls_in_if import tls_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [TEMP_W-1:0]   temperature;
    logic        [SUPPLY_W-1:0] supply_level;

    modport source (output valid, temperature, supply_level, input ready);
    modport sink   (input valid, temperature, supply_level, output ready);
endinterface

interface tls_out_if import tls_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     logged;
    logic       [FRAME_W-1:0] frame_word;
    logic signed [TEMP_W-1:0] minimum;
    logic signed [TEMP_W-1:0] maximum;
    logic signed [TEMP_W-1:0] average;

    modport source (output valid, logged, frame_word, minimum, maximum, average,
                    input ready);
    modport sink   (input valid, logged, frame_word, minimum, maximum, average,
                    output ready);
endinterface
`default_nettype wire

// File: hdl/temperature_log_stats_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// temperature_log_stats_top
// decimated temperature logger with ring statistics and radio frame
// ----------------------------------------------------------------------------
// One word in gives one word out. Every log_interval-th sample (and the first
// after reset) is written to a ring of LOG_DEPTH entries and a 4-byte frame
// is built; each result carries min, max and the average truncated toward zero
// over the valid ring entries, or zeros while the ring is empty. After a word
// is accepted the ring is updated, the valid ring entries are scanned one
// entry per cycle through the ring memory's single read port, then a
// twelve-step restoring divider forms the average, and the result is loaded
// into the output register once the previous result has left it. A new
// sample is taken while the previous result still waits in the output
// register. The ring needs no clearing after reset, since only written entries
// are ever scanned.
module temperature_log_stats_top import tls_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    tls_in_if.sink                     i_in,
    tls_out_if.source                  o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [INTERVAL_W-1:0] i_cfg_wdata
);

    t_cmd    w_cmd;
    t_status w_status;

    tls_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    tls_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

endmodule
`default_nettype wire

// File: hdl/tls_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tls_ctrl
// sequencer: capture, ring update, ring scan, divide, result hand-off
// ----------------------------------------------------------------------------
module tls_ctrl import tls_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_status.in_valid) n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.scan_done) n_state = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (i_status.div_done) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.capture  = i_status.in_valid;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.div_load  = i_status.scan_done;
            end
            ST_DIVIDE: begin
                o_cmd.div_step = !i_status.div_done;
            end
            ST_DONE: begin
                o_cmd.result_load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/tls_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tls_datapath
// decimation counter, log ring memory, min/max/sum scan, divider, output
// register
// ----------------------------------------------------------------------------
module tls_datapath import tls_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    tls_in_if.sink                     i_in,
    tls_out_if.source                  o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [INTERVAL_W-1:0] i_cfg_wdata
);

    // configuration and decimation state
    logic [INTERVAL_W-1:0]     r_interval;
    logic [INTERVAL_W-1:0]     r_sample_cnt;
    logic [IDX_W-1:0]          r_wp;
    logic                      r_filled;

    // captured word
    logic signed [TEMP_W-1:0]  r_temp;
    logic [SUPPLY_W-1:0]       r_supply;
    logic                      r_logged;
    logic [CNT_W-1:0]          r_count;

    // ring
    logic signed [TEMP_W-1:0]  r_ring [LOG_DEPTH];
    logic signed [TEMP_W-1:0]  r_rdata;

    // scan
    logic [CNT_W-1:0]          r_addr;
    logic                      r_pend;
    logic                      r_have;
    logic signed [TEMP_W-1:0]  r_min;
    logic signed [TEMP_W-1:0]  r_max;
    logic signed [SUM_W-1:0]   r_sum;

    // divider
    logic                      r_neg;
    logic [CNT_W-1:0]          r_rem;
    logic [Q_W-1:0]            r_dvd_lo;
    logic [Q_W-1:0]            r_quo;
    logic [DIVC_W-1:0]         r_div_left;

    // output register
    logic                      r_out_valid;
    logic                      r_o_logged;
    logic [FRAME_W-1:0]        r_o_frame;
    logic signed [TEMP_W-1:0]  r_o_min;
    logic signed [TEMP_W-1:0]  r_o_max;
    logic signed [TEMP_W-1:0]  r_o_avg;

    logic [INTERVAL_W:0]       w_next;
    logic                      w_log;
    logic                      w_wp_last;
    logic [IDX_W-1:0]          n_wp;
    logic                      n_filled;
    logic [CNT_W-1:0]          n_count;
    logic                      w_issue;
    logic [SUM_W-1:0]          w_mag;
    logic [CNT_W:0]            w_trial;
    logic                      w_ge;
    logic [Q_W-1:0]            w_avg;
    logic [15:0]               w_t16;
    logic [7:0]                w_x;
    logic [3:0]                w_cs;
    logic [FRAME_W-1:0]        w_frame;

    // decimation and ring pointer
    always_comb begin
        w_next    = {1'b0, r_sample_cnt} + (INTERVAL_W + 1)'(1);
        w_log     = w_next >= {1'b0, r_interval};
        w_wp_last = r_wp == IDX_W'(LOG_DEPTH - 1);
        n_wp      = r_wp;
        n_filled  = r_filled;
        if (w_log) begin
            n_wp = w_wp_last ? '0 : r_wp + IDX_W'(1);
            if (w_wp_last) n_filled = 1'b1;
        end
        n_count = n_filled ? CNT_W'(LOG_DEPTH) : CNT_W'(n_wp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval   <= INTERVAL_RESET;
            r_sample_cnt <= COUNTER_RESET;
            r_wp         <= '0;
            r_filled     <= 1'b0;
        end else begin
            if (i_cfg_we) r_interval <= i_cfg_wdata;
            if (i_cmd.update) begin
                r_sample_cnt <= w_log ? '0 : w_next[INTERVAL_W-1:0];
                r_wp         <= n_wp;
                r_filled     <= n_filled;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_temp   <= i_in.temperature;
            r_supply <= i_in.supply_level;
        end
        if (i_cmd.update) begin
            r_logged <= w_log;
            r_count  <= n_count;
        end
    end

    assign w_issue = i_cmd.scan_step && (r_addr != r_count);

    // ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && w_log) r_ring[r_wp] <= r_temp;
        if (w_issue) r_rdata <= r_ring[r_addr[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= w_issue;
        end
    end

    // scan accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_addr <= '0;
            r_have <= 1'b0;
            r_min  <= '0;
            r_max  <= '0;
            r_sum  <= '0;
        end else begin
            if (w_issue) r_addr <= r_addr + CNT_W'(1);
            if (r_pend) begin
                r_have <= 1'b1;
                if (!r_have || r_rdata < r_min) r_min <= r_rdata;
                if (!r_have || r_rdata > r_max) r_max <= r_rdata;
                r_sum <= r_sum + {{(SUM_W - TEMP_W){r_rdata[TEMP_W-1]}}, r_rdata};
            end
        end
    end

    // restoring divide of |sum| by count; the quotient never needs more than Q_W bits
    always_comb begin
        w_mag   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : r_sum;
        w_trial = {r_rem, r_dvd_lo[Q_W-1]};
        w_ge    = w_trial >= {1'b0, r_count};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_left <= '0;
        end else if (i_cmd.div_load) begin
            r_div_left <= DIVC_W'(Q_W);
        end else if (i_cmd.div_step) begin
            r_div_left <= r_div_left - DIVC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_neg    <= r_sum[SUM_W-1];
            r_rem    <= w_mag[SUM_W-1:Q_W];
            r_dvd_lo <= w_mag[Q_W-1:0];
            r_quo    <= '0;
        end else if (i_cmd.div_step) begin
            r_rem    <= w_ge ? CNT_W'(w_trial - {1'b0, r_count}) : w_trial[CNT_W-1:0];
            r_quo    <= {r_quo[Q_W-2:0], w_ge};
            r_dvd_lo <= {r_dvd_lo[Q_W-2:0], 1'b0};
        end
    end

    // result word
    always_comb begin
        if (r_count == '0) begin
            w_avg = '0;
        end else begin
            w_avg = r_neg ? Q_W'(-r_quo) : r_quo;
        end
        w_t16 = {{(16 - TEMP_W){r_temp[TEMP_W-1]}}, r_temp};
        w_x   = {4'h0, FRAME_TYPE} ^ r_supply ^ w_t16[7:0] ^ w_t16[15:8];
        w_cs  = w_x[3:0] ^ w_x[7:4] ^ CHECKSUM_XOR;
        if (r_logged) begin
            w_frame = {w_t16[15:8], w_t16[7:0], r_supply, w_cs, FRAME_TYPE};
        end else begin
            w_frame = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.result_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result_load) begin
            r_o_logged <= r_logged;
            r_o_frame  <= w_frame;
            r_o_min    <= r_min;
            r_o_max    <= r_max;
            r_o_avg    <= $signed(w_avg);
        end
    end

    assign i_in.ready         = i_cmd.in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.logged       = r_o_logged;
    assign o_out.frame_word   = r_o_frame;
    assign o_out.minimum      = r_o_min;
    assign o_out.maximum      = r_o_max;
    assign o_out.average      = r_o_avg;

    assign o_status.in_valid  = i_in.valid;
    assign o_status.scan_done = (r_addr == r_count) && !r_pend;
    assign o_status.div_done  = r_div_left == '0;
    assign o_status.out_free  = !r_out_valid || o_out.ready;

endmodule
`default_nettype wire

// File: hdl/tls_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tls_checker
// port-level checks on the result channel of the temperature logger
// ----------------------------------------------------------------------------
module tls_checker import tls_pkg::*; (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_valid,
    input wire logic                     i_ready,
    input wire logic                     i_logged,
    input wire logic [FRAME_W-1:0]       i_frame,
    input wire logic signed [TEMP_W-1:0] i_min,
    input wire logic signed [TEMP_W-1:0] i_max,
    input wire logic signed [TEMP_W-1:0] i_avg
);

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_frame) && $stable(i_logged)
            && $stable(i_min) && $stable(i_max) && $stable(i_avg))
        else $error("result word changed while stalled");

    // no frame unless the sample was logged
    a_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_logged |-> i_frame == '0)
        else $error("frame present on an unlogged sample");

    // frame type, nibble checksum and sign-extended top byte
    a_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_logged |-> i_frame[3:0] == FRAME_TYPE
            && i_frame[7:4] == (FRAME_TYPE ^ CHECKSUM_XOR ^ i_frame[11:8]
                ^ i_frame[15:12] ^ i_frame[19:16] ^ i_frame[23:20]
                ^ i_frame[27:24] ^ i_frame[31:28])
            && i_frame[31:28] == {4{i_frame[27]}})
        else $error("malformed frame");

    // average lies between minimum and maximum
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_min <= i_avg && i_avg <= i_max)
        else $error("statistics out of order");

endmodule

bind temperature_log_stats_top tls_checker u_tls_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_out.valid),
    .i_ready  (o_out.ready),
    .i_logged (o_out.logged),
    .i_frame  (o_out.frame_word),
    .i_min    (o_out.minimum),
    .i_max    (o_out.maximum),
    .i_avg    (o_out.average)
);
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the decimated temperature logger
// ----------------------------------------------------------------------------
// A short table of samples and interval writes runs first. A few of its rows
// carry hand-worked results; all other rows, and the random phases that
// follow, are checked against a behavioural model of the logger kept here.
// Both channels stall at random. Interval writes only happen once every
// result has drained.
module tb;
    import tls_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        logic                     logged;
        logic [FRAME_W-1:0]       frame;
        logic signed [TEMP_W-1:0] minimum;
        logic signed [TEMP_W-1:0] maximum;
        logic signed [TEMP_W-1:0] average;
    } t_stats;

    typedef enum logic {ROW_SAMPLE, ROW_INTERVAL} t_row_kind;

    typedef struct {
        t_row_kind                  kind;
        logic [INTERVAL_W-1:0]      interval;
        logic signed [TEMP_W-1:0]   temperature;
        logic [SUPPLY_W-1:0]        supply;
        bit                         worked;
        t_stats                     want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [INTERVAL_W-1:0] cfg_wdata;

    tls_in_if  sample_ch ();
    tls_out_if result_ch ();

    temperature_log_stats_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (sample_ch),
        .o_out       (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // model state of the logger
    logic [INTERVAL_W-1:0]    mdl_interval;
    logic [INTERVAL_W-1:0]    mdl_counter;
    int                       mdl_wpos;
    bit                       mdl_filled;
    logic signed [TEMP_W-1:0] mdl_ring [LOG_DEPTH];

    t_stats pending_stats [$];
    t_row   directed_rows [$];
    int     error_count;
    int     cycle_count;
    bit     tx_calm;
    bit     rx_calm;
    int     rx_hold;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void reset_model();
        mdl_interval = INTERVAL_RESET;
        mdl_counter  = COUNTER_RESET;
        mdl_wpos     = 0;
        mdl_filled   = 1'b0;
        for (int i = 0; i < LOG_DEPTH; i++)
            mdl_ring[i] = '0;
    endfunction

    function automatic t_stats log_sample(logic signed [TEMP_W-1:0] temp,
                                          logic [SUPPLY_W-1:0] supply);
        t_stats     r;
        int         next_count;
        int         valid_count;
        int         lo;
        int         hi;
        int         sum;
        logic [15:0] temp16;
        logic [7:0]  xsum;
        logic [3:0]  csum;
        r.logged = 1'b0;
        r.frame = '0;
        r.minimum = '0;
        r.maximum = '0;
        r.average = '0;
        // counter increment does not wrap, so 255 always logs
        next_count = int'(mdl_counter) + 1;
        if (next_count >= int'(mdl_interval)) begin
            mdl_counter = '0;
            r.logged = 1'b1;
            temp16 = {{(16 - TEMP_W){temp[TEMP_W-1]}}, temp};
            xsum = {4'h0, FRAME_TYPE} ^ supply ^ temp16[7:0] ^ temp16[15:8];
            csum = xsum[3:0] ^ xsum[7:4] ^ CHECKSUM_XOR;
            r.frame = {temp16[15:8], temp16[7:0], supply, csum, FRAME_TYPE};
            mdl_ring[mdl_wpos] = temp;
            mdl_wpos++;
            if (mdl_wpos == LOG_DEPTH) begin
                mdl_wpos = 0;
                mdl_filled = 1'b1;
            end
        end else begin
            mdl_counter = next_count[INTERVAL_W-1:0];
        end
        valid_count = mdl_filled ? LOG_DEPTH : mdl_wpos;
        if (valid_count > 0) begin
            lo = mdl_ring[0];
            hi = mdl_ring[0];
            sum = 0;
            for (int i = 0; i < valid_count; i++) begin
                if (mdl_ring[i] < lo) lo = mdl_ring[i];
                if (mdl_ring[i] > hi) hi = mdl_ring[i];
                sum += mdl_ring[i];
            end
            r.minimum = lo[TEMP_W-1:0];
            r.maximum = hi[TEMP_W-1:0];
            // integer division truncates toward zero
            r.average = 12'(sum / valid_count);
        end
        return r;
    endfunction

    // table helpers
    function automatic void add_interval(int v);
        t_row r;
        r = '{kind: ROW_INTERVAL, default: '0};
        r.interval = v[INTERVAL_W-1:0];
        directed_rows.push_back(r);
    endfunction

    function automatic void add_sample(int t, int s);
        t_row r;
        r = '{kind: ROW_SAMPLE, default: '0};
        r.temperature = t[TEMP_W-1:0];
        r.supply = s[SUPPLY_W-1:0];
        directed_rows.push_back(r);
    endfunction

    function automatic void add_worked(int t, int s, bit lg, logic [31:0] fw,
                                       int mn, int mx, int av);
        t_row r;
        r = '{kind: ROW_SAMPLE, default: '0};
        r.temperature = t[TEMP_W-1:0];
        r.supply = s[SUPPLY_W-1:0];
        r.worked = 1'b1;
        r.want.logged = lg;
        r.want.frame = fw;
        r.want.minimum = mn[TEMP_W-1:0];
        r.want.maximum = mx[TEMP_W-1:0];
        r.want.average = av[TEMP_W-1:0];
        directed_rows.push_back(r);
    endfunction

    // called in the step of the previous acceptance, so valid is never lowered
    // and raised again in one step
    task automatic send_sample(logic signed [TEMP_W-1:0] temp,
                               logic [SUPPLY_W-1:0] supply, bit worked,
                               t_stats want);
        int     gap;
        t_stats predicted;
        if ($urandom_range(0, 31) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.temperature <= temp;
        sample_ch.supply_level <= supply;
        @(posedge i_clk);
        while (!sample_ch.ready)
            @(posedge i_clk);
        predicted = log_sample(temp, supply);
        pending_stats.push_back(worked ? want : predicted);
    endtask

    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_interval(logic [INTERVAL_W-1:0] v);
        // block is idle only once every word has come out
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        mdl_interval = v;
    endtask

    task automatic check_result();
        t_stats want;
        if (pending_stats.size() == 0) begin
            $error("result word with nothing expected");
            error_count++;
        end else begin
            want = pending_stats.pop_front();
            if (result_ch.logged !== want.logged) begin
                $error("logged: expected %0d, got %0d", want.logged, result_ch.logged);
                error_count++;
            end
            if (result_ch.frame_word !== want.frame) begin
                $error("frame_word: expected %h, got %h", want.frame,
                       result_ch.frame_word);
                error_count++;
            end
            if (result_ch.minimum !== want.minimum) begin
                $error("minimum: expected %0d, got %0d", want.minimum,
                       result_ch.minimum);
                error_count++;
            end
            if (result_ch.maximum !== want.maximum) begin
                $error("maximum: expected %0d, got %0d", want.maximum,
                       result_ch.maximum);
                error_count++;
            end
            if (result_ch.average !== want.average) begin
                $error("average: expected %0d, got %0d", want.average,
                       result_ch.average);
                error_count++;
            end
        end
    endtask

    // result side: stall count only runs down while a word is offered
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                check_result();
                if ($urandom_range(0, 31) == 0)
                    rx_calm = !rx_calm;
                rx_hold = rx_calm ? 0 : $urandom_range(0, 5);
            end else if (result_ch.valid && rx_hold > 0) begin
                rx_hold--;
            end
            result_ch.ready <= (rx_hold == 0);
        end
    end

    initial begin
        int     phase_interval [6];
        int     phase_items [6];
        int     t;
        t_stats none;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        sample_ch.valid = 1'b0;
        sample_ch.temperature = '0;
        sample_ch.supply_level = '0;
        tx_calm = 1'b0;
        none = '{default: '0};
        reset_model();

        // first sample after reset logs at once, the next one does not
        add_worked(-2048, 8'hFF, 1'b1, 32'hF800FF02, -2048, -2048, -2048);
        add_worked(2047, 8'h00, 1'b0, 32'h0, -2048, -2048, -2048);
        add_interval(1);
        // -2048 + 2047 averages to zero under truncation
        add_worked(2047, 8'h00, 1'b1, 32'h07FF0002, -2048, 2047, 0);
        add_sample(0, 8'h55);
        add_sample(-1, 8'hAA);
        add_sample(1, 8'h0F);
        add_sample(1365, 8'hF0);
        add_sample(-1366, 8'h01);
        add_sample(100, 8'h80);
        add_sample(-100, 8'h7F);
        add_sample(-2048, 8'h33);
        add_sample(2047, 8'hCC);
        // these wrap the ring
        add_sample(7, 8'h5A);
        add_sample(-7, 8'hA5);
        // interval zero behaves like one
        add_interval(0);
        add_sample(-500, 8'h12);
        add_sample(500, 8'h34);
        add_interval(2);
        add_sample(3, 8'h00);
        add_sample(-3, 8'hFF);
        add_sample(9, 8'h99);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_INTERVAL)
                write_interval(directed_rows[i].interval);
            else
                send_sample(directed_rows[i].temperature, directed_rows[i].supply,
                            directed_rows[i].worked, directed_rows[i].want);
        end

        phase_interval = '{1, 5, 255, 0, 2, 0};
        phase_items    = '{200, 200, 300, 100, 200, 300};
        phase_interval[5] = $urandom_range(1, 12);
        for (int p = 0; p < 6; p++) begin
            write_interval(phase_interval[p][INTERVAL_W-1:0]);
            for (int n = 0; n < phase_items[p]; n++) begin
                case ($urandom_range(0, 15))
                    0: t = -2048;
                    1: t = 2047;
                    2: t = $urandom_range(0, 1) ? 0 : -1;
                    default: t = $urandom;
                endcase
                send_sample(t[TEMP_W-1:0], SUPPLY_W'($urandom), 1'b0, none);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
